// ===== rtl/gray_world_white_balance_top_macros.svh =====
// ----------------------------------------------------------------------------
// Gray-world white balance assertion macros
// Shared concurrent assertion shorthands, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef GRAY_WORLD_WHITE_BALANCE_TOP_MACROS_SVH
`define GRAY_WORLD_WHITE_BALANCE_TOP_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define GWWB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define GWWB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gwwb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray-world white balance package
// Widths, constants, lane control struct and the pixel scaling function.
// ----------------------------------------------------------------------------
package gwwb_pkg;

    localparam int PIX_W             = 8;
    localparam int FRAME_PIXELS_LOG2 = 22;
    localparam int GAIN_FRAC_BITS    = 16;

    localparam int SUM_W   = FRAME_PIXELS_LOG2 + PIX_W;
    localparam int TOT_W   = SUM_W + 2;
    localparam int DIV_W   = SUM_W + 2;
    localparam int GAIN_W  = PIX_W + GAIN_FRAC_BITS;
    localparam int NUM_W   = TOT_W + GAIN_FRAC_BITS;
    localparam int SHD_W   = DIV_W + GAIN_W;
    localparam int PROD_W  = PIX_W + GAIN_W;
    localparam int RND_W   = PROD_W + 1;
    localparam int SHR_W   = RND_W - GAIN_FRAC_BITS;
    localparam int CNT_W   = $clog2(GAIN_W);

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [PIX_W-1:0]  PIX_MAX  = '1;
    localparam logic [RND_W-1:0]  RND_HALF = RND_W'(1) << (GAIN_FRAC_BITS - 1);

    typedef struct packed {
        logic acc_en;
        logic calc;
        logic load;
        logic step;
        logic finish;
    } gwwb_ctrl_t;

    // Multiply by a Q8.F gain, round half up, saturate to the pixel range.
    function automatic logic [PIX_W-1:0] scale_pix(input logic [PIX_W-1:0] v,
                                                   input logic [GAIN_W-1:0] g);
        logic [RND_W-1:0] acc;
        logic [SHR_W-1:0] shr;
        acc = RND_W'(PROD_W'(v) * PROD_W'(g)) + RND_HALF;
        shr = acc[RND_W-1:GAIN_FRAC_BITS];
        return (shr > SHR_W'(PIX_MAX)) ? PIX_MAX : shr[PIX_W-1:0];
    endfunction

endpackage

// ===== rtl/gwwb_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray-world white balance stream interfaces
// Valid/ready channels for incoming pixels and corrected pixels.
// ----------------------------------------------------------------------------
interface gwwb_in_if
    import gwwb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             last;

    modport source (output valid, action, blue, green, red, last, input ready);
    modport sink   (input valid, action, blue, green, red, last, output ready);
endinterface

interface gwwb_out_if
    import gwwb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] red_out;
    logic             last_out;

    modport source (output valid, blue_out, green_out, red_out, last_out, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, last_out, output ready);
endinterface

// ===== rtl/gwwb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray-world white balance channel lane
// Channel sum, gain register, bit-serial gain divider and pixel scaler.
// ----------------------------------------------------------------------------
module gwwb_lane
    import gwwb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gwwb_ctrl_t        ctrl,
    input  logic [PIX_W-1:0]  pix,
    input  logic [TOT_W-1:0]  total,
    output logic [SUM_W-1:0]  sum,
    output logic [GAIN_W-1:0] gain,
    output logic [PIX_W-1:0]  scaled
);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [GAIN_W-1:0] gain_reg;
    logic [DIV_W-1:0]  div_reg;
    logic              zero_reg;
    logic              sat_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [SHD_W-1:0]  shd_reg;
    logic [GAIN_W-1:0] quo_reg;

    logic [SUM_W:0]    acc_wide;
    logic [NUM_W-1:0]  num;
    logic              fits;

    assign acc_wide = {1'b0, sum_reg} + (SUM_W+1)'(pix);
    assign num      = {total, {GAIN_FRAC_BITS{1'b0}}};
    assign fits     = SHD_W'(rem_reg) >= shd_reg;

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.load)
        begin
            sum_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            sum_next = acc_wide[SUM_W] ? SUM_MAX : acc_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            gain_reg <= GAIN_ONE;
        end
        else
        begin
            sum_reg <= sum_next;
            if (ctrl.finish)
            begin
                gain_reg <= zero_reg ? GAIN_ONE : (sat_reg ? GAIN_MAX : quo_reg);
            end
        end
    end

    // Restoring division of total * 2^F by 3 * sum, one quotient bit a cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.calc)
        begin
            div_reg  <= DIV_W'(sum_reg) + (DIV_W'(sum_reg) << 1);
            zero_reg <= (sum_reg == '0);
        end
        if (ctrl.load)
        begin
            rem_reg <= num;
            shd_reg <= SHD_W'(div_reg) << (GAIN_W - 1);
            sat_reg <= SHD_W'(num) >= (SHD_W'(div_reg) << GAIN_W);
        end
        else if (ctrl.step)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - shd_reg[NUM_W-1:0];
            end
            shd_reg <= shd_reg >> 1;
            quo_reg <= {quo_reg[GAIN_W-2:0], fits};
        end
    end

    assign sum    = sum_reg;
    assign gain   = gain_reg;
    assign scaled = scale_pix(pix, gain_reg);

endmodule

// ===== rtl/gwwb_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray-world white balance merge and sequencer
// Combines the lane sums into the frame total and steps the gain update.
// ----------------------------------------------------------------------------
module gwwb_merge
    import gwwb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             stat_beat,
    input  logic             stat_last,
    input  logic [SUM_W-1:0] sum_b,
    input  logic [SUM_W-1:0] sum_g,
    input  logic [SUM_W-1:0] sum_r,
    output gwwb_ctrl_t       ctrl,
    output logic [TOT_W-1:0] total,
    output logic             busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [TOT_W-1:0] total_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat_beat && stat_last)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
                cnt_next   = CNT_W'(GAIN_W - 1);
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            total_reg <= TOT_W'(sum_b) + TOT_W'(sum_g) + TOT_W'(sum_r);
        end
    end

    assign ctrl.acc_en = stat_beat;
    assign ctrl.calc   = (state_reg == ST_CALC);
    assign ctrl.load   = (state_reg == ST_LOAD);
    assign ctrl.step   = (state_reg == ST_DIV);
    assign ctrl.finish = (state_reg == ST_DONE);
    assign total       = total_reg;
    assign busy        = (state_reg != ST_IDLE);

endmodule

// ===== rtl/gray_world_white_balance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray-world white balance top level
// Three channel lanes, a merge/sequencer and a registered output stage.
// ----------------------------------------------------------------------------
//  Channel   Role    Beat carries
//  pix_in    sink    action, blue, green, red, last
//  pix_out   source  blue_out, green_out, red_out, last_out
//
//  Either pass, statistics or apply, streams at one beat per clock while
//  the output side keeps up.
//  The last statistics beat starts a gain update (total, load, one quotient
//  bit per cycle in each lane's divider, write-back); pix_in.ready stays
//  low throughout.
//  Reset clears the sums to zero and sets every gain to 1.0.
//  A stalled output holds its beat; pix_in keeps accepting while the held
//  beat is taken in the same cycle.
// ----------------------------------------------------------------------------
module gray_world_white_balance_top
    import gwwb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    gwwb_in_if.sink           pix_in,
    gwwb_out_if.source        pix_out
);

`include "gray_world_white_balance_top_macros.svh"

    // Handshake decode. Statistics beats never produce an output beat, but
    // ready is kept independent of the payload for a clean handshake.
    logic             busy;
    logic             in_beat;
    logic             stat_beat;
    logic             apply_beat;

    gwwb_ctrl_t       ctrl;
    logic [TOT_W-1:0] total;
    logic [SUM_W-1:0] sum_b;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_r;
    logic [GAIN_W-1:0] gain_b;
    logic [GAIN_W-1:0] gain_g;
    logic [GAIN_W-1:0] gain_r;
    logic [PIX_W-1:0] scaled_b;
    logic [PIX_W-1:0] scaled_g;
    logic [PIX_W-1:0] scaled_r;

    // Output stage registers.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] blue_out_reg;
    logic [PIX_W-1:0] green_out_reg;
    logic [PIX_W-1:0] red_out_reg;
    logic             last_out_reg;

    assign pix_in.ready = !busy && (!out_valid_reg || pix_out.ready);
    assign in_beat      = pix_in.valid && pix_in.ready;
    assign stat_beat    = in_beat && !pix_in.action;
    assign apply_beat   = in_beat && pix_in.action;

    // One lane per color channel; each keeps its own sum, gain and divider.
    gwwb_lane u_lane_b
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .pix    (pix_in.blue),
        .total  (total),
        .sum    (sum_b),
        .gain   (gain_b),
        .scaled (scaled_b)
    );

    gwwb_lane u_lane_g
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .pix    (pix_in.green),
        .total  (total),
        .sum    (sum_g),
        .gain   (gain_g),
        .scaled (scaled_g)
    );

    gwwb_lane u_lane_r
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .pix    (pix_in.red),
        .total  (total),
        .sum    (sum_r),
        .gain   (gain_r),
        .scaled (scaled_r)
    );

    // The merge stage adds the three lane sums and sequences the division.
    gwwb_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat_beat (stat_beat),
        .stat_last (pix_in.last),
        .sum_b     (sum_b),
        .sum_g     (sum_g),
        .sum_r     (sum_r),
        .ctrl      (ctrl),
        .total     (total),
        .busy      (busy)
    );

    // An apply beat loads the output register; a taken beat empties it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_beat)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_beat)
        begin
            blue_out_reg  <= scaled_b;
            green_out_reg <= scaled_g;
            red_out_reg   <= scaled_r;
            last_out_reg  <= pix_in.last;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.blue_out  = blue_out_reg;
    assign pix_out.green_out = green_out_reg;
    assign pix_out.red_out   = red_out_reg;
    assign pix_out.last_out  = last_out_reg;

    // While the gains are being recomputed no pixel may enter.
    `GWWB_ASSERT_IMP(a_busy_blocks_input, busy, !pix_in.ready, "pixel accepted during gain update")
    // The last statistics beat must start the gain update.
    `GWWB_ASSERT_NEXT(a_last_starts_update, stat_beat && pix_in.last, busy, "gain update not started")
    // An accepted apply beat must show up on the output next cycle.
    `GWWB_ASSERT_NEXT(a_apply_fills_output, apply_beat, pix_out.valid, "apply beat lost")
    // Gains change only in the write-back cycle of an update.
    `GWWB_ASSERT_NEXT(a_gain_only_at_finish, !ctrl.finish, $stable(gain_b) && $stable(gain_g) && $stable(gain_r), "gain changed outside update")

endmodule

// ===== tb/gray_world_white_balance_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray-world white balance testbench
// Sends statistics and apply passes through the pixel stream and predicts
// every corrected pixel from its own copy of the channel sums and gains.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                       action;
    logic [gwwb_pkg::PIX_W-1:0] blue;
    logic [gwwb_pkg::PIX_W-1:0] green;
    logic [gwwb_pkg::PIX_W-1:0] red;
    logic                       last;
} wb_pixel_t;

typedef struct packed {
    logic [gwwb_pkg::PIX_W-1:0] blue;
    logic [gwwb_pkg::PIX_W-1:0] green;
    logic [gwwb_pkg::PIX_W-1:0] red;
    logic                       last;
} wb_corrected_t;

// Keeps the running channel sums and gains and the queue of corrected
// pixels that the block still owes.
class wb_scoreboard;
    longint unsigned blue_total;
    longint unsigned green_total;
    longint unsigned red_total;
    logic [gwwb_pkg::GAIN_W-1:0] blue_gain;
    logic [gwwb_pkg::GAIN_W-1:0] green_gain;
    logic [gwwb_pkg::GAIN_W-1:0] red_gain;
    wb_corrected_t corrected_q[$];
    int errors;

    function new();
        blue_total  = 0;
        green_total = 0;
        red_total   = 0;
        blue_gain   = gwwb_pkg::GAIN_ONE;
        green_gain  = gwwb_pkg::GAIN_ONE;
        red_gain    = gwwb_pkg::GAIN_ONE;
        errors      = 0;
    endfunction

    function int pending();
        return corrected_q.size();
    endfunction

    function longint unsigned add_clamped(longint unsigned acc, logic [gwwb_pkg::PIX_W-1:0] v);
        longint unsigned limit;
        longint unsigned t;
        limit = (64'd1 << gwwb_pkg::SUM_W) - 64'd1;
        t = acc + 64'(v);
        return (t > limit) ? limit : t;
    endfunction

    // Gain = grand / (3 * chan) in unsigned Q8.F, truncated and clamped.
    function logic [gwwb_pkg::GAIN_W-1:0] derive_gain(longint unsigned grand,
                                                      longint unsigned chan);
        longint unsigned q;
        if (chan == 0)
            return gwwb_pkg::GAIN_ONE;
        q = (grand << gwwb_pkg::GAIN_FRAC_BITS) / (64'd3 * chan);
        if (q > 64'(gwwb_pkg::GAIN_MAX))
            return gwwb_pkg::GAIN_MAX;
        return q[gwwb_pkg::GAIN_W-1:0];
    endfunction

    function logic [gwwb_pkg::PIX_W-1:0] apply_gain(logic [gwwb_pkg::PIX_W-1:0] v,
                                                    logic [gwwb_pkg::GAIN_W-1:0] g);
        longint unsigned p;
        p = (64'(v) * 64'(g) + (64'd1 << (gwwb_pkg::GAIN_FRAC_BITS - 1)))
            >> gwwb_pkg::GAIN_FRAC_BITS;
        return (p > 64'd255) ? 8'd255 : p[gwwb_pkg::PIX_W-1:0];
    endfunction

    function void note_pixel(wb_pixel_t p);
        wb_corrected_t c;
        longint unsigned grand;
        if (p.action == 1'b0)
        begin
            blue_total  = add_clamped(blue_total, p.blue);
            green_total = add_clamped(green_total, p.green);
            red_total   = add_clamped(red_total, p.red);
            if (p.last)
            begin
                grand       = blue_total + green_total + red_total;
                blue_gain   = derive_gain(grand, blue_total);
                green_gain  = derive_gain(grand, green_total);
                red_gain    = derive_gain(grand, red_total);
                blue_total  = 0;
                green_total = 0;
                red_total   = 0;
            end
        end
        else
        begin
            c.blue  = apply_gain(p.blue, blue_gain);
            c.green = apply_gain(p.green, green_gain);
            c.red   = apply_gain(p.red, red_gain);
            c.last  = p.last;
            corrected_q.push_back(c);
        end
    endfunction

    task report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task check_result(wb_corrected_t got);
        wb_corrected_t want;
        if (corrected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat b=%0d g=%0d r=%0d last=%0d",
                                      got.blue, got.green, got.red, got.last));
            return;
        end
        want = corrected_q.pop_front();
        if (got.blue !== want.blue)
            report_mismatch($sformatf("blue_out %0d, want %0d", got.blue, want.blue));
        if (got.green !== want.green)
            report_mismatch($sformatf("green_out %0d, want %0d", got.green, want.green));
        if (got.red !== want.red)
            report_mismatch($sformatf("red_out %0d, want %0d", got.red, want.red));
        if (got.last !== want.last)
            report_mismatch($sformatf("last_out %0d, want %0d", got.last, want.last));
    endtask
endclass

module gray_world_white_balance_top_tb;
    import gwwb_pkg::*;

    // Generous ceiling: the slowest legal run, with the longest gaps on both
    // sides for every beat, stays under a tenth of it.
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_BEATS = 1550;
    // The drain allows for the gain update after the last statistics beat.
    localparam int DRAIN_CYCLES = 64;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   beats_in;
    bit   steady_in;

    wb_scoreboard wb;

    gwwb_in_if  pix_in();
    gwwb_out_if pix_out();

    gray_world_white_balance_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one beat and hold it until the block takes it. When no gap is
    // wanted, valid simply stays high and only the payload changes, so valid
    // never gets two assignments in one time step.
    task automatic send_pixel(input logic action, input logic [PIX_W-1:0] blue,
                              input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] red,
                              input logic last);
        wb_pixel_t p;
        int        gap;
        p   = '{action: action, blue: blue, green: green, red: red, last: last};
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid  <= 1'b1;
        pix_in.action <= action;
        pix_in.blue   <= blue;
        pix_in.green  <= green;
        pix_in.red    <= red;
        pix_in.last   <= last;
        do
            @(posedge clk);
        while (!pix_in.ready);
        wb.note_pixel(p);
        beats_in++;
    endtask

    // Hand-picked beats: pass-through before any statistics, a channel whose
    // sum is zero, a gain that clamps at its maximum, an all-black frame, a
    // perfectly gray frame, and last markers in the apply pass.
    task automatic run_directed();
        // Reset gains of 1.0 pass pixels through untouched.
        send_pixel(1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(1'b1, 8'h55, 8'hAA, 8'h0F, 1'b0);
        // Blue never lit: its gain falls back to 1.0.
        send_pixel(1'b0, 8'd0, 8'd128, 8'd64, 1'b0);
        send_pixel(1'b0, 8'd0, 8'd255, 8'd1, 1'b1);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(1'b1, 8'd200, 8'd100, 8'd7, 1'b1);
        // Nearly no blue: the blue gain clamps, and its products clamp at 255.
        send_pixel(1'b0, 8'd1, 8'd255, 8'd255, 1'b0);
        send_pixel(1'b0, 8'd0, 8'd255, 8'd255, 1'b1);
        send_pixel(1'b1, 8'd1, 8'd0, 8'd0, 1'b0);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(1'b1, 8'd128, 8'd128, 8'd128, 1'b1);
        // A single black pixel: every sum is zero, so all gains reset to 1.0.
        send_pixel(1'b0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(1'b1, 8'd255, 8'd0, 8'd255, 1'b0);
        // Pure white statistics give exactly 1.0 on every channel.
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(1'b1, 8'd128, 8'd64, 8'd32, 1'b1);
        send_pixel(1'b1, 8'd17, 8'd240, 8'd99, 1'b0);
        // Mild cast, then extremes through the resulting fractional gains.
        send_pixel(1'b0, 8'd10, 8'd20, 8'd30, 1'b0);
        send_pixel(1'b0, 8'd10, 8'd20, 8'd30, 1'b1);
        send_pixel(1'b1, 8'd255, 8'd127, 8'd1, 1'b0);
        send_pixel(1'b1, 8'd0, 8'd255, 8'd255, 1'b1);
    endtask

    function automatic logic [PIX_W-1:0] pick_value(int lo, int hi);
        return PIX_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [PIX_W-1:0] pick_apply_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return pick_value(0, 255);
    endfunction

    // One random frame. Most are a full statistics pass followed by an apply
    // pass; the rest are broken: apply without fresh statistics, statistics
    // never applied, or apply passes with stray last markers.
    task automatic run_frame();
        int lo[3];
        int hi[3];
        int kind;
        int mode;
        int n_stats;
        int n_apply;
        kind      = $urandom_range(0, 99);
        steady_in = ($urandom_range(0, 3) == 0);
        // Per-channel color cast; some channels are dark or nearly dark so
        // that gains fall back to 1.0 or clamp.
        for (int c = 0; c < 3; c++)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                lo[c] = 0;
                hi[c] = 0;
            end
            else if (mode == 1)
            begin
                lo[c] = 0;
                hi[c] = 2;
            end
            else if (mode < 5)
            begin
                lo[c] = 0;
                hi[c] = 255;
            end
            else
            begin
                lo[c] = $urandom_range(0, 200);
                hi[c] = lo[c] + $urandom_range(0, 55);
            end
        end
        n_stats = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
        n_apply = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);

        if (kind < 85 || (kind >= 92 && kind < 96))
        begin
            for (int i = 0; i < n_stats; i++)
                send_pixel(1'b0, pick_value(lo[0], hi[0]), pick_value(lo[1], hi[1]),
                           pick_value(lo[2], hi[2]), i == n_stats - 1);
        end
        if (kind < 92)
        begin
            for (int i = 0; i < n_apply; i++)
                send_pixel(1'b1, pick_apply_value(), pick_apply_value(), pick_apply_value(),
                           (kind < 85) ? (i == n_apply - 1) : 1'($urandom_range(0, 1)));
        end
        else if (kind >= 96)
        begin
            for (int i = 0; i < n_apply; i++)
                send_pixel(1'b1, pick_apply_value(), pick_apply_value(), pick_apply_value(),
                           $urandom_range(0, 3) == 0);
        end
    endtask

    // Output side: random stalls, quiet stretches with ready held high, and
    // two long hold-offs while the sender keeps offering beats, so the block
    // fills up and has to drop pix_in.ready.
    initial
    begin
        int            stall_left;
        int            hold_left;
        int            mode_left;
        int            beats_out;
        int            gap;
        bit            steady_out;
        wb_corrected_t got;
        stall_left = 0;
        hold_left  = 0;
        mode_left  = 0;
        beats_out  = 0;
        steady_out = 1'b0;
        pix_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_out.valid && pix_out.ready)
            begin
                got = '{blue: pix_out.blue_out, green: pix_out.green_out,
                        red: pix_out.red_out, last: pix_out.last_out};
                wb.check_result(got);
                beats_out++;
                if (beats_out == 150 || beats_out == 500)
                    hold_left = 300;
            end
            if (mode_left == 0)
            begin
                steady_out = ($urandom_range(0, 3) == 0);
                mode_left  = $urandom_range(50, 300);
            end
            else
                mode_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pix_out.ready <= 1'b0;
            end
            else if (steady_out)
                pix_out.ready <= 1'b1;
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                    stall_left = gap - 1;
                pix_out.ready <= (gap == 0);
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        wb          = new();
        cycle_count = 0;
        beats_in    = 0;
        steady_in   = 1'b0;
        rst_n         <= 1'b0;
        pix_in.valid  <= 1'b0;
        pix_in.action <= 1'b0;
        pix_in.blue   <= '0;
        pix_in.green  <= '0;
        pix_in.red    <= '0;
        pix_in.last   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        while (beats_in < RANDOM_BEATS)
            run_frame();
        pix_in.valid <= 1'b0;

        // Let every owed pixel arrive, then allow for a gain update still in
        // flight and any stray beat the block might produce.
        while (wb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (wb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
